// File: hdl/tsdt_pkg.sv
// Types and codes shared by the TCP sequence delta tracker.
// No dependencies.
package tsdt_pkg;

    typedef enum logic [1:0] {
        REQ_RECORD    = 2'd0,
        REQ_ACK_QUERY = 2'd1,
        REQ_SEQ_QUERY = 2'd2,
        REQ_UNUSED    = 2'd3
    } req_t;

    // One ring entry as held in the entry memory.
    typedef struct packed {
        logic [31:0] old_end;
        logic [31:0] new_end;
        logic [31:0] change;
    } entry_t;

endpackage

// File: hdl/tcp_sequence_delta_tracker_unit.sv
// TCP sequence delta tracker: ring of sequence adjustments in one entry memory.
// Depends on tsdt_pkg (request codes, entry layout).
//
//  channel  ports                                     dir  accepted when
//  s_       req_type tcp_number ip_header_words       in   s_valid && s_ready
//           tcp_header_words total_length length_change
//  m_       adjustment matched                        out  m_valid && m_ready
//
// A record is accepted, then written to the entry memory in ST_REC.
// A query does one memory read per entry, feeds a two-stage difference/compare
// pipe behind the single read port, and then loads the result register.
// Request code 3 is taken and dropped.
// Synchronous active-low reset clears control, valid bits and the write slot;
// entry memory contents are not cleared. The result register holds a finished
// item while a new item is accepted; a query waits at its end if it is still full.
module tcp_sequence_delta_tracker_unit #(
    parameter int ENTRIES = 20
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic [31:0]        s_tcp_number,
    input  logic [3:0]         s_ip_header_words,
    input  logic [3:0]         s_tcp_header_words,
    input  logic [15:0]        s_total_length,
    input  logic signed [31:0] s_length_change,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_adjustment,
    output logic               m_matched
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_REC    = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_DRAIN  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    tsdt_pkg::entry_t entry_mem [ENTRIES];
    tsdt_pkg::entry_t rd_data_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic               rd_vbit_reg;

    logic [IDX_W-1:0] wr_slot_reg;
    logic [IDX_W-1:0] rd_idx_reg;

    logic [31:0] number_reg;
    logic [31:0] old_end_reg;
    logic [31:0] change_reg;
    logic        use_new_reg;

    logic        rd_pend_reg, rd_last_reg;
    logic        p2_valid_reg, p2_last_reg, p2_cand_reg;
    logic [31:0] p2_diff_reg, p2_change_reg;

    logic        found_reg;
    logic [31:0] best_diff_reg, best_change_reg;

    logic        m_valid_reg, m_matched_reg;
    logic [31:0] m_adj_reg;

    logic        s_accept;
    logic        mem_we, rd_en;
    logic [6:0]  hdr_bytes;
    logic [31:0] payload_len;
    logic [31:0] ref_end;
    logic        out_free;
    tsdt_pkg::entry_t wr_entry;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign mem_we   = (state_reg == ST_REC);
    assign rd_en    = (state_reg == ST_SCAN);

    assign hdr_bytes   = {({1'b0, s_ip_header_words} + {1'b0, s_tcp_header_words}), 2'b00};
    assign payload_len = {16'd0, s_total_length} - {25'd0, hdr_bytes};

    assign wr_entry.old_end = old_end_reg;
    assign wr_entry.new_end = old_end_reg + change_reg;
    assign wr_entry.change  = change_reg;

    assign ref_end = use_new_reg ? rd_data_reg.new_end : rd_data_reg.old_end;

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            entry_mem[wr_slot_reg] <= wr_entry;
        end
        if (rd_en) begin
            rd_data_reg <= entry_mem[rd_idx_reg];
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    priority if (tsdt_pkg::req_t'(s_req_type) == tsdt_pkg::REQ_RECORD) begin
                        state_next = ST_REC;
                    end else if (tsdt_pkg::req_t'(s_req_type) == tsdt_pkg::REQ_ACK_QUERY ||
                                 tsdt_pkg::req_t'(s_req_type) == tsdt_pkg::REQ_SEQ_QUERY) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_REC:  state_next = ST_IDLE;
            ST_SCAN: begin
                if (rd_idx_reg == LAST_IDX) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (p2_valid_reg && p2_last_reg) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            wr_slot_reg  <= '0;
            rd_idx_reg   <= '0;
            rd_pend_reg  <= 1'b0;
            rd_last_reg  <= 1'b0;
            p2_valid_reg <= 1'b0;
            p2_last_reg  <= 1'b0;
            found_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (mem_we) begin
                valid_reg[wr_slot_reg] <= 1'b1;
                wr_slot_reg <= (wr_slot_reg == LAST_IDX) ? '0 : wr_slot_reg + 1'b1;
            end

            if (s_accept) begin
                rd_idx_reg <= '0;
                found_reg  <= 1'b0;
            end else if (rd_en) begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end

            rd_pend_reg  <= rd_en;
            rd_last_reg  <= rd_en && (rd_idx_reg == LAST_IDX);
            p2_valid_reg <= rd_pend_reg;
            p2_last_reg  <= rd_last_reg;

            // Strict compare with an ascending scan keeps the lowest index on ties.
            if (p2_valid_reg && p2_cand_reg && !p2_diff_reg[31] &&
                (!found_reg || p2_diff_reg < best_diff_reg)) begin
                found_reg <= 1'b1;
            end

            if (state_reg == ST_FINISH && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            number_reg  <= s_tcp_number;
            old_end_reg <= s_tcp_number + payload_len;
            change_reg  <= s_length_change;
            use_new_reg <= (tsdt_pkg::req_t'(s_req_type) == tsdt_pkg::REQ_ACK_QUERY);
        end
        if (rd_en) begin
            rd_vbit_reg <= valid_reg[rd_idx_reg];
        end
        p2_diff_reg   <= number_reg - ref_end;
        p2_change_reg <= rd_data_reg.change;
        p2_cand_reg   <= rd_vbit_reg;
        if (s_accept) begin
            best_change_reg <= '0;
        end else if (p2_valid_reg && p2_cand_reg && !p2_diff_reg[31] &&
                     (!found_reg || p2_diff_reg < best_diff_reg)) begin
            best_diff_reg   <= p2_diff_reg;
            best_change_reg <= p2_change_reg;
        end
        if (state_reg == ST_FINISH && out_free) begin
            m_adj_reg     <= best_change_reg;
            m_matched_reg <= found_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_adjustment = m_adj_reg;
    assign m_matched    = m_matched_reg;

    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result item appeared outside the finish state");

    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && rd_en))
        else $error("entry memory written and scanned in the same cycle");

    a_pipe_follows_read: assert property (@(posedge aclk) disable iff (!aresetn)
        p2_valid_reg |-> $past(rd_pend_reg))
        else $error("compare stage active without a preceding read");

    a_idle_pipe_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (!p2_valid_reg && !rd_pend_reg))
        else $error("scan pipe busy while accepting items");

endmodule

// File: tb/tcp_sequence_delta_tracker_unit_tb.sv
// Testbench for tcp_sequence_delta_tracker_unit: directed table, then random requests,
// each result checked against a typed expectation or an in-bench model of the adjustment ring.
// Depends on tsdt_pkg and the tcp_sequence_delta_tracker_unit RTL.
`timescale 1ns / 1ps

module tcp_sequence_delta_tracker_unit_tb;

    localparam int RING_DEPTH   = 20;
    localparam int ITEMS_PER_PH = 200;
    localparam int STALL_LIMIT  = 3000;

    typedef struct {
        logic signed [31:0] adjustment;
        logic               matched;
    } adj_result_t;

    typedef struct {
        tsdt_pkg::req_t req;
        logic [31:0]    number;
        logic [3:0]     ipw;
        logic [3:0]     tcpw;
        logic [15:0]    total;
        logic [31:0]    change;
        bit             typed;
        adj_result_t    res;
    } stim_row_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_req_type;
    logic [31:0]        s_tcp_number;
    logic [3:0]         s_ip_header_words;
    logic [3:0]         s_tcp_header_words;
    logic [15:0]        s_total_length;
    logic signed [31:0] s_length_change;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_adjustment;
    logic               m_matched;

    tcp_sequence_delta_tracker_unit #(.ENTRIES(RING_DEPTH)) dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_req_type         (s_req_type),
        .s_tcp_number       (s_tcp_number),
        .s_ip_header_words  (s_ip_header_words),
        .s_tcp_header_words (s_tcp_header_words),
        .s_total_length     (s_total_length),
        .s_length_change    (s_length_change),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_adjustment       (m_adjustment),
        .m_matched          (m_matched)
    );

    // model of the adjustment ring
    logic [31:0] ring_old_end [RING_DEPTH];
    logic [31:0] ring_new_end [RING_DEPTH];
    logic [31:0] ring_change  [RING_DEPTH];
    bit          ring_valid   [RING_DEPTH];
    int          ring_slot;

    adj_result_t pending_adjustments[$];
    stim_row_t   directed_rows[$];
    int          error_count;
    int          src_idle_pct;
    int          rcv_idle_pct;
    int          stall_cycles;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic void log_length_change(logic [31:0] seq, logic [3:0] ipw,
                                               logic [3:0] tcpw, logic [15:0] total,
                                               logic [31:0] change);
        logic [31:0] hdr_bytes;
        logic [31:0] old_end;
        hdr_bytes = ({28'd0, ipw} + {28'd0, tcpw}) << 2;
        old_end = seq + ({16'd0, total} - hdr_bytes);
        ring_old_end[ring_slot] = old_end;
        ring_new_end[ring_slot] = old_end + change;
        ring_change[ring_slot]  = change;
        ring_valid[ring_slot]   = 1'b1;
        ring_slot = (ring_slot == RING_DEPTH - 1) ? 0 : ring_slot + 1;
    endfunction

    function automatic adj_result_t lookup_adjustment(logic [31:0] number, bit use_new);
        adj_result_t res;
        logic [31:0] diff;
        logic [31:0] best_diff;
        res.adjustment = '0;
        res.matched    = 1'b0;
        best_diff      = '0;
        for (int i = 0; i < RING_DEPTH; i++) begin
            if (ring_valid[i]) begin
                diff = number - (use_new ? ring_new_end[i] : ring_old_end[i]);
                // negative signed distance: entry lies ahead of the number
                if (!diff[31] && (!res.matched || diff < best_diff)) begin
                    res.matched    = 1'b1;
                    best_diff      = diff;
                    res.adjustment = ring_change[i];
                end
            end
        end
        return res;
    endfunction

    task automatic add_row(tsdt_pkg::req_t req, logic [31:0] number, logic [3:0] ipw,
                           logic [3:0] tcpw, logic [15:0] total, logic [31:0] change,
                           bit typed, logic signed [31:0] adj, logic matched);
        stim_row_t row;
        row.req = req;
        row.number = number;
        row.ipw = ipw;
        row.tcpw = tcpw;
        row.total = total;
        row.change = change;
        row.typed = typed;
        row.res.adjustment = adj;
        row.res.matched = matched;
        directed_rows.push_back(row);
    endtask

    // Drive one item at the falling edge and hold it until the block takes it.
    task automatic send_item(stim_row_t row);
        adj_result_t res;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_req_type         <= row.req;
        s_tcp_number       <= row.number;
        s_ip_header_words  <= row.ipw;
        s_tcp_header_words <= row.tcpw;
        s_total_length     <= row.total;
        s_length_change    <= row.change;
        s_valid            <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        case (row.req)
            tsdt_pkg::REQ_RECORD: log_length_change(row.number, row.ipw, row.tcpw,
                                                    row.total, row.change);
            tsdt_pkg::REQ_ACK_QUERY, tsdt_pkg::REQ_SEQ_QUERY: begin
                res = row.typed ? row.res
                                : lookup_adjustment(row.number,
                                                    row.req == tsdt_pkg::REQ_ACK_QUERY);
                pending_adjustments.push_back(res);
            end
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (pending_adjustments.size() != 0)
            @(posedge aclk);
    endtask

    task automatic random_phase(int count);
        stim_row_t   row;
        stim_row_t   last_rec;
        logic [31:0] stream_seq;
        logic [31:0] base;
        int          k;
        int          sent;
        int          pick;
        sent = 0;
        stream_seq = $urandom;
        last_rec.req = tsdt_pkg::REQ_RECORD;
        last_rec.number = stream_seq;
        last_rec.ipw = 4'd5;
        last_rec.tcpw = 4'd5;
        last_rec.total = 16'd540;
        last_rec.change = 32'd8;
        last_rec.typed = 1'b0;
        while (sent < count) begin
            row.typed  = 1'b0;
            row.number = $urandom;
            row.ipw    = 4'($urandom_range(15));
            row.tcpw   = 4'($urandom_range(15));
            row.total  = 16'($urandom_range(65535));
            row.change = $urandom;
            pick = $urandom_range(99);
            if (pick < 5) begin
                row.req = tsdt_pkg::REQ_UNUSED;
            end else if (pick < 40) begin
                row.req = tsdt_pkg::REQ_RECORD;
                if ($urandom_range(9) == 0) begin
                    // identical record: query ties go to the lower slot
                    row = last_rec;
                end else begin
                    if ($urandom_range(9) < 7)
                        row.number = stream_seq;
                    if ($urandom_range(3) != 0) begin
                        row.ipw   = 4'($urandom_range(5, 15));
                        row.tcpw  = 4'($urandom_range(5, 15));
                        row.total = 16'($urandom_range(40, 1500));
                    end
                    if ($urandom_range(9) < 6)
                        row.change = 32'($urandom_range(128)) - 32'd64;
                end
                stream_seq = row.number + {16'd0, row.total};
                last_rec = row;
            end else begin
                row.req = (pick < 70) ? tsdt_pkg::REQ_ACK_QUERY : tsdt_pkg::REQ_SEQ_QUERY;
                if (ring_valid[0] && $urandom_range(99) < 85) begin
                    do k = $urandom_range(RING_DEPTH - 1); while (!ring_valid[k]);
                    base = (row.req == tsdt_pkg::REQ_ACK_QUERY) ? ring_new_end[k]
                                                                : ring_old_end[k];
                    case ($urandom_range(3))
                        0: row.number = base;
                        1: row.number = base + 32'($urandom_range(40));
                        2: row.number = base - 32'($urandom_range(1, 40));
                        default: row.number = base + 32'($urandom_range(3000));
                    endcase
                end
            end
            send_item(row);
            if (row.req != tsdt_pkg::REQ_UNUSED)
                sent++;
        end
    endtask

    // result side: random stalls, checks at the rising edge
    always @(negedge aclk)
        m_ready <= ($urandom_range(99) >= rcv_idle_pct);

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_adjustments.size() == 0) begin
                $display("%0t: result with nothing expected: adjustment %0d matched %0b",
                         $time, m_adjustment, m_matched);
                error_count++;
            end else begin
                if (m_adjustment !== pending_adjustments[0].adjustment) begin
                    $display("%0t: adjustment mismatch: expected %0d actual %0d",
                             $time, pending_adjustments[0].adjustment, m_adjustment);
                    error_count++;
                end
                if (m_matched !== pending_adjustments[0].matched) begin
                    $display("%0t: matched mismatch: expected %0b actual %0b",
                             $time, pending_adjustments[0].matched, m_matched);
                    error_count++;
                end
                void'(pending_adjustments.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_req_type         = tsdt_pkg::REQ_RECORD;
        s_tcp_number       = '0;
        s_ip_header_words  = '0;
        s_tcp_header_words = '0;
        s_total_length     = '0;
        s_length_change    = '0;
        m_ready            = 1'b0;
        error_count        = 0;
        stall_cycles       = 0;
        ring_slot          = 0;
        src_idle_pct       = 10;
        rcv_idle_pct       = 54;
        for (int i = 0; i < RING_DEPTH; i++)
            ring_valid[i] = 1'b0;

        // empty ring, extremes, header longer than packet, ties, unused code
        add_row(tsdt_pkg::REQ_ACK_QUERY, 32'h0000_0000, 4'd0, 4'd0, 16'd0, 32'd0,
                1, 32'd0, 1'b0);
        add_row(tsdt_pkg::REQ_SEQ_QUERY, 32'hFFFF_FFFF, 4'd0, 4'd0, 16'd0, 32'd0,
                1, 32'd0, 1'b0);
        add_row(tsdt_pkg::REQ_UNUSED, 32'h1234_5678, 4'd3, 4'd7, 16'd99, 32'd5,
                0, 32'd0, 1'b0);
        add_row(tsdt_pkg::REQ_RECORD, 32'hFFFF_FFFF, 4'd15, 4'd15, 16'hFFFF, 32'h7FFF_FFFF,
                0, 32'd0, 1'b0);
        add_row(tsdt_pkg::REQ_SEQ_QUERY, 32'h0000_FF86, 4'd0, 4'd0, 16'd0, 32'd0,
                1, 32'sh7FFF_FFFF, 1'b1);
        add_row(tsdt_pkg::REQ_ACK_QUERY, 32'h8000_FF85, 4'd0, 4'd0, 16'd0, 32'd0,
                1, 32'sh7FFF_FFFF, 1'b1);
        add_row(tsdt_pkg::REQ_SEQ_QUERY, 32'h0000_FF85, 4'd0, 4'd0, 16'd0, 32'd0,
                1, 32'd0, 1'b0);
        add_row(tsdt_pkg::REQ_RECORD, 32'd100, 4'd15, 4'd15, 16'd0, 32'h8000_0000,
                0, 32'd0, 1'b0);
        add_row(tsdt_pkg::REQ_SEQ_QUERY, 32'hFFFF_FFEC, 4'd0, 4'd0, 16'd0, 32'd0,
                1, 32'sh8000_0000, 1'b1);
        add_row(tsdt_pkg::REQ_ACK_QUERY, 32'h7FFF_FFEC, 4'd0, 4'd0, 16'd0, 32'd0,
                1, 32'sh8000_0000, 1'b1);
        add_row(tsdt_pkg::REQ_RECORD, 32'd1000, 4'd5, 4'd5, 16'd140, 32'd0,
                0, 32'd0, 1'b0);
        add_row(tsdt_pkg::REQ_RECORD, 32'd1000, 4'd5, 4'd5, 16'd140, 32'd12,
                0, 32'd0, 1'b0);
        add_row(tsdt_pkg::REQ_SEQ_QUERY, 32'd1100, 4'd0, 4'd0, 16'd0, 32'd0,
                0, 32'd0, 1'b0);
        add_row(tsdt_pkg::REQ_ACK_QUERY, 32'd1111, 4'd0, 4'd0, 16'd0, 32'd0,
                0, 32'd0, 1'b0);
        add_row(tsdt_pkg::REQ_RECORD, 32'd0, 4'd0, 4'd0, 16'd0, 32'd0,
                0, 32'd0, 1'b0);
        add_row(tsdt_pkg::REQ_SEQ_QUERY, 32'd0, 4'd0, 4'd0, 16'd0, 32'd0,
                0, 32'd0, 1'b0);
        add_row(tsdt_pkg::REQ_ACK_QUERY, 32'h7FFF_FFFF, 4'd0, 4'd0, 16'd0, 32'd0,
                0, 32'd0, 1'b0);
        add_row(tsdt_pkg::REQ_SEQ_QUERY, 32'h8000_0000, 4'd0, 4'd0, 16'd0, 32'd0,
                0, 32'd0, 1'b0);
        add_row(tsdt_pkg::REQ_RECORD, 32'd5, 4'd5, 4'd10, 16'd60, 32'hFFFF_FFFF,
                0, 32'd0, 1'b0);
        add_row(tsdt_pkg::REQ_ACK_QUERY, 32'd4, 4'd0, 4'd0, 16'd0, 32'd0,
                0, 32'd0, 1'b0);
        add_row(tsdt_pkg::REQ_UNUSED, 32'hFFFF_FFFF, 4'd15, 4'd15, 16'hFFFF, 32'hFFFF_FFFF,
                0, 32'd0, 1'b0);

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i]);
        random_phase(ITEMS_PER_PH);

        // sender holds off until the block has delivered everything
        s_valid <= 1'b0;
        wait_drained();
        @(negedge aclk);
        src_idle_pct = 54;
        rcv_idle_pct = 10;
        random_phase(ITEMS_PER_PH);

        src_idle_pct = 0;
        rcv_idle_pct = 0;
        random_phase(ITEMS_PER_PH);

        s_valid <= 1'b0;
        wait_drained();
        repeat (RING_DEPTH + 10) @(posedge aclk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: files.f
hdl/tsdt_pkg.sv
hdl/tcp_sequence_delta_tracker_unit.sv
tb/tcp_sequence_delta_tracker_unit_tb.sv
